// ===== rtl/fbatp_pkg.sv =====
// Shared types and constants for the five-bit address text packer.
// No dependencies; used by the top, fbatp_map and fbatp_store.
package fbatp_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int SYM_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 5;
    localparam int WORD_W      = 80;
    localparam int HEAD_W      = 16;
    localparam int TAIL_W      = 64;
    localparam int IDX_W       = 4;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } fbatp_sym_t;

    typedef struct packed {
        logic add_en;
        logic finish_en;
    } fbatp_ctl_t;

endpackage

// ===== rtl/five_bit_address_text_packer_top.sv =====
// Top level of the five-bit address text packer: input register, decoder,
// symbol store and result register. Depends on fbatp_pkg, fbatp_map, fbatp_store.
//
// Usage:
//   The slave channel carries one transaction per character. s_tuser is the
//   operation (0 = add character, 1 = finish); s_tdata is the character byte.
//   Characters outside 0-9, a-z, A-Z are dropped; after 16 symbols further
//   characters are ignored. A finish transaction emits one 80-bit word on
//   the master channel and clears the store. Add transactions emit nothing.
//   m_tdata[15:0] is bits 79..64 of the packed word, m_tdata[79:16] bits 63..0.
//   Path: an accepted finish sits in the input register, and the store's word
//   then loads the result register, which drives m_tvalid.
//   Throughput: one transaction per cycle while no finish waits on a stalled
//   result; the store updates between the input and result registers.
//   Reset (aresetn low, synchronous) empties the store and clears both
//   valid flags. When the receiver stalls, the result is held; add
//   transactions keep flowing, and a finish waits in the input register,
//   which drops s_tready until the result is taken.
module five_bit_address_text_packer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [15:0] packed_head, [79:16] packed_tail
);

    logic                           in_valid_reg;
    logic                           in_op_reg;
    logic [fbatp_pkg::CHAR_W-1:0]   in_char_reg;
    logic                           m_tvalid_reg;
    logic [fbatp_pkg::WORD_W-1:0]   out_word_reg;
    logic [fbatp_pkg::WORD_W-1:0]   word;
    logic                           go;
    fbatp_pkg::fbatp_sym_t          sym;
    fbatp_pkg::fbatp_ctl_t          ctl;

    assign go = in_valid_reg &&
                (in_op_reg == fbatp_pkg::OP_ADD || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;

    assign ctl.add_en    = go && (in_op_reg == fbatp_pkg::OP_ADD);
    assign ctl.finish_en = go && (in_op_reg == fbatp_pkg::OP_FINISH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    fbatp_map u_map (
        .char_in (in_char_reg),
        .sym_out (sym)
    );

    fbatp_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sym     (sym),
        .word    (word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.finish_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.finish_en) begin
            out_word_reg <= word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_word_reg[fbatp_pkg::TAIL_W-1:0],
                       out_word_reg[fbatp_pkg::WORD_W-1:fbatp_pkg::TAIL_W]};

endmodule

// ===== rtl/fbatp_map.sv =====
// Character decoder: maps one byte to a 5-bit symbol with a valid flag.
// Depends on fbatp_pkg.
module fbatp_map (
    input  logic [fbatp_pkg::CHAR_W-1:0] char_in,
    output fbatp_pkg::fbatp_sym_t        sym_out
);

    logic [fbatp_pkg::CHAR_W-1:0] lc;

    always_comb begin
        lc = char_in;
        if (char_in >= 8'h41 && char_in <= 8'h5A) begin
            lc = char_in + 8'h20;
        end
    end

    always_comb begin
        sym_out.valid = 1'b1;
        sym_out.sym   = '0;
        unique case (lc) inside
            [8'h30:8'h39]: sym_out.sym = fbatp_pkg::SYM_W'(lc - 8'h30);
            8'h6F:         sym_out.sym = 5'd0;
            8'h69, 8'h6C:  sym_out.sym = 5'd1;
            [8'h61:8'h68]: sym_out.sym = fbatp_pkg::SYM_W'(lc - 8'h57);
            8'h6A:         sym_out.sym = 5'd18;
            8'h6B:         sym_out.sym = 5'd19;
            8'h6D:         sym_out.sym = 5'd20;
            8'h6E:         sym_out.sym = 5'd21;
            [8'h70:8'h75]: sym_out.sym = fbatp_pkg::SYM_W'(lc - 8'h5A);
            8'h76, 8'h77:  sym_out.sym = 5'd28;
            [8'h78:8'h7A]: sym_out.sym = fbatp_pkg::SYM_W'(lc - 8'h5B);
            default:       sym_out.valid = 1'b0;
        endcase
    end

endmodule

// ===== rtl/fbatp_store.sv =====
// Symbol store and count, with the packed-word formatter.
// Depends on fbatp_pkg.
module fbatp_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fbatp_pkg::fbatp_ctl_t         ctl,
    input  fbatp_pkg::fbatp_sym_t         sym,
    output logic [fbatp_pkg::WORD_W-1:0]  word
);

    logic [fbatp_pkg::SYM_W-1:0]   store_reg [fbatp_pkg::STORE_DEPTH];
    logic [fbatp_pkg::COUNT_W-1:0] count_reg;
    logic [fbatp_pkg::COUNT_W-1:0] count_next;
    logic                          full;
    logic                          wr_en;

    assign full  = count_reg[fbatp_pkg::COUNT_W-1];
    assign wr_en = ctl.add_en && sym.valid && !full;

    always_comb begin
        count_next = count_reg;
        if (ctl.finish_en) begin
            count_next = '0;
        end else if (wr_en) begin
            count_next = count_reg + fbatp_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[count_reg[fbatp_pkg::IDX_W-1:0]] <= sym.sym;
        end
    end

    always_comb begin
        word = '0;
        word[fbatp_pkg::WORD_W-1] = full;
        word[78:75] = full ? store_reg[fbatp_pkg::STORE_DEPTH-1][3:0]
                           : count_reg[fbatp_pkg::IDX_W-1:0];
        for (int k = 0; k < fbatp_pkg::STORE_DEPTH - 1; k++) begin
            word[74-5*k -: fbatp_pkg::SYM_W] =
                (fbatp_pkg::COUNT_W'(k) < count_reg) ? store_reg[k] : '0;
        end
    end

endmodule

// ===== rtl/fbatp_checker.sv =====
// Port-level checks for the five-bit address text packer, bound to the top.
// Depends on five_bit_address_text_packer_top.
module fbatp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_rise_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
        else $error("result without finish transaction two cycles earlier");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output free");

endmodule

bind five_bit_address_text_packer_top fbatp_checker u_fbatp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
